@@ sv/ppcm_pkg.sv @@
// Shared types, constants and helper functions of the pitch PD controller.
`timescale 1ns / 1ps
package ppcm_pkg;

   typedef enum logic [2:0] {
      REG_GAIN_ANGLE  = 3'd0,
      REG_GAIN_RATE   = 3'd1,
      REG_AMPLITUDE   = 3'd2,
      REG_PHASE_STEP  = 3'd3,
      REG_HOVER_FORCE = 3'd4,
      REG_ARM_LENGTH  = 3'd5,
      REG_SPIN_GAIN   = 3'd6,
      REG_SPIN_OFFSET = 3'd7
   } reg_idx_type;

   localparam logic [23:0] GAIN_ANGLE_RST  = 24'd65536;
   localparam logic [23:0] GAIN_RATE_RST   = 24'd65536;
   localparam logic [16:0] AMPLITUDE_RST   = 17'd0;
   localparam logic [31:0] PHASE_STEP_RST  = 32'd858993;
   localparam logic [23:0] HOVER_FORCE_RST = 24'd455950;
   localparam logic [15:0] ARM_LENGTH_RST  = 16'd11236;
   localparam logic [23:0] SPIN_GAIN_RST   = 24'd7986217;
   localparam logic [23:0] SPIN_OFFSET_RST = 24'd1712587;

   // pi/180000 in Q40, 0.0154*pi/180 in Q32, turns per millidegree in Q48
   localparam logic signed [31:0] THETA_K = 32'sd19190098;
   localparam logic signed [31:0] OMEGA_K = 32'sd1154404;
   localparam logic signed [31:0] TURN_K  = 32'sd781874935;

   localparam logic signed [17:0] COS_FLOOR = 18'sd1024;

   localparam int CW = 34;       // CORDIC datapath width
   localparam int DIVW = 46;     // divider dividend width
   localparam int DVSW = 17;     // divider divisor width
   localparam int SQW = 64;      // square root radicand width

   localparam logic signed [CW-1:0] CORDIC_INIT = 34'sd652032874;

   typedef logic signed [CW-1:0] cw_type;

   function automatic cw_type atan_turn(input logic [3:0] i);
      cw_type v;
      case (i)
         4'd0:    v = 34'sd536870912;
         4'd1:    v = 34'sd316933406;
         4'd2:    v = 34'sd167458907;
         4'd3:    v = 34'sd85004756;
         4'd4:    v = 34'sd42667331;
         4'd5:    v = 34'sd21354465;
         4'd6:    v = 34'sd10679838;
         4'd7:    v = 34'sd5340245;
         4'd8:    v = 34'sd2670163;
         4'd9:    v = 34'sd1335087;
         4'd10:   v = 34'sd667544;
         4'd11:   v = 34'sd333772;
         4'd12:   v = 34'sd166886;
         4'd13:   v = 34'sd83443;
         4'd14:   v = 34'sd41722;
         4'd15:   v = 34'sd20861;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Round Q30 to Q16 and clamp to +-1.0
   function automatic logic signed [17:0] to_q16(input cw_type v);
      logic signed [CW:0] s;
      logic signed [CW:0] q;
      logic signed [17:0] r;
      s = {v[CW-1], v} + 35'sd8192;
      q = s >>> 14;
      if (q > 35'sd65536) begin
         r = 18'sd65536;
      end else if (q < -35'sd65536) begin
         r = -18'sd65536;
      end else begin
         r = q[17:0];
      end
      return r;
   endfunction

endpackage

@@ sv/ppcm_if.sv @@
// Channel interfaces for pitch samples and motor commands.
`timescale 1ns / 1ps
interface ppcm_req_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] pitch_raw;
   logic signed [15:0] pitch_rate_raw;
   modport source (output valid, output pitch_raw, output pitch_rate_raw, input ready);
   modport sink   (input valid, input pitch_raw, input pitch_rate_raw, output ready);
endinterface

interface ppcm_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         motor_front;
   logic [7:0]         motor_back;
   logic signed [17:0] desired_pitch;
   modport source (output valid, output motor_front, output motor_back,
                   output desired_pitch, input ready);
   modport sink   (input valid, input motor_front, input motor_back,
                   input desired_pitch, output ready);
endinterface

@@ sv/ppcm_cordic.sv @@
// Iterative CORDIC giving sine and cosine of a 32-bit turn angle, one step a cycle.
`timescale 1ns / 1ps
module ppcm_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               done,
   output logic signed [17:0] sin_q16,
   output logic signed [17:0] cos_q16
);
   ppcm_pkg::cw_type x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic             busy_ff, busy_in, done_ff, done_in, flip_ff, flip_in;
   logic [3:0]       iter_ff, iter_in;
   logic [31:0]      a_rot;
   logic             flip_now;
   logic [31:0]      a_plus;
   ppcm_pkg::cw_type dx, dy, at;

   always_comb begin
      a_plus   = angle + 32'h4000_0000;
      flip_now = a_plus[31];
      a_rot    = flip_now ? angle + 32'h8000_0000 : angle;
      dx       = y_ff >>> iter_ff;
      dy       = x_ff >>> iter_ff;
      at       = ppcm_pkg::atan_turn(iter_ff);
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      flip_in  = flip_ff;
      iter_in  = iter_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         x_in    = ppcm_pkg::CORDIC_INIT;
         y_in    = '0;
         z_in    = {{2{a_rot[31]}}, a_rot};
         flip_in = flip_now;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[ppcm_pkg::CW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         iter_in = iter_ff + 4'd1;
         if (iter_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      iter_ff <= iter_in;
   end

   logic signed [17:0] s_r, c_r;
   always_comb begin
      s_r     = ppcm_pkg::to_q16(y_ff);
      c_r     = ppcm_pkg::to_q16(x_ff);
      sin_q16 = flip_ff ? -s_r : s_r;
      cos_q16 = flip_ff ? -c_r : c_r;
   end

   assign done = done_ff;
endmodule

@@ sv/ppcm_divider.sv @@
// Restoring unsigned divider, one quotient bit a cycle.
`timescale 1ns / 1ps
module ppcm_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ppcm_pkg::DIVW-1:0]     dividend,
   input  logic [ppcm_pkg::DVSW-1:0]     divisor,
   output logic                          done,
   output logic [ppcm_pkg::DIVW-1:0]     quotient
);
   logic [ppcm_pkg::DIVW-1:0] quo_ff, quo_in;
   logic [ppcm_pkg::DVSW-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [ppcm_pkg::DVSW:0]   rem_sh;
   logic [5:0]                cnt_ff, cnt_in;
   logic                      busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[ppcm_pkg::DIVW-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = ppcm_pkg::DVSW'(rem_sh - {1'b0, dvs_ff});
            quo_in = {quo_ff[ppcm_pkg::DIVW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[ppcm_pkg::DVSW-1:0];
            quo_in = {quo_ff[ppcm_pkg::DIVW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(ppcm_pkg::DIVW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

@@ sv/ppcm_sqrt.sv @@
// Integer floor square root, one root bit a cycle.
`timescale 1ns / 1ps
module ppcm_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ppcm_pkg::SQW-1:0]   radicand,
   output logic                       done,
   output logic [ppcm_pkg::SQW/2-1:0] root
);
   localparam int RW = ppcm_pkg::SQW / 2;
   logic [ppcm_pkg::SQW-1:0] val_ff, val_in;
   logic [RW-1:0]            root_ff, root_in;
   logic [RW+1:0]            rem_ff, rem_in;
   logic [RW+2:0]            rem_sh, trial;
   logic [4:0]               cnt_ff, cnt_in;
   logic                     busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_sh  = {rem_ff[RW:0], val_ff[ppcm_pkg::SQW-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      val_in  = val_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[ppcm_pkg::SQW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (RW+2)'(rem_sh - trial);
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RW+1:0];
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(RW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

@@ sv/pitch_pd_control_motor_mix.sv @@
// Pitch PD controller with two-rotor mixing: sequencer, shared multiplier and units.
// Each sample passes through two 16-step CORDIC runs, two 46-step divisions, two
// 32-step square roots and the multiplier steps. A new sample is taken only once
// the previous result is in the output register, which can wait on rsp_chan.ready.
// Reset (synchronous, high) clears phase and restores registers.
`timescale 1ns / 1ps
module pitch_pd_control_motor_mix (
   input  logic        clock,
   input  logic        reset,
   ppcm_req_if.sink    req_chan,
   ppcm_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wr_data
);
   typedef enum logic [4:0] {
      S_IDLE, S_SIN_START, S_SIN_WAIT, S_M_DES, S_M_THETA, S_M_OMEGA, S_M_TURN,
      S_M_E1, S_M_E2, S_U2, S_COS_WAIT, S_DIV1_START, S_DIV1_WAIT, S_DIV2_START,
      S_DIV2_WAIT, S_FORCE, S_SQ_START, S_SQ_WAIT, S_M_CMD, S_CMD, S_OUT
   } state_type;

   state_type state_ff;

   logic [23:0] gain_angle_ff, gain_rate_ff, hover_force_ff, spin_gain_ff, spin_offset_ff;
   logic [16:0] amplitude_ff;
   logic [31:0] phase_step_ff, phase_ff;
   logic [15:0] arm_length_ff;

   logic signed [17:0] p_ff;
   logic signed [15:0] r_ff;
   logic signed [17:0] sn_ff, cs_ff, des_ff;
   logic signed [18:0] theta_ff;
   logic signed [20:0] omega_ff;
   logic [31:0]        pturn_ff;
   logic signed [27:0] e1_ff;
   logic signed [29:0] u2_ff;
   logic [30:0]        u4_ff;
   logic signed [46:0] t_ff, ff_front, ff_back;
   logic [30:0]        s_ff;
   logic               side_ff;
   logic [7:0]         mf_ff, mb_ff, cmd;

   logic               rsp_valid_ff;
   logic [7:0]         out_front_ff, out_back_ff;
   logic signed [17:0] out_des_ff;

   // shared multiplier
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff;
   logic signed [19:0] diff;

   always_comb begin
      diff  = {theta_ff[18], theta_ff} - {{2{des_ff[17]}}, des_ff};
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_M_DES: begin
            mul_a = {15'b0, amplitude_ff};
            mul_b = {{14{sn_ff[17]}}, sn_ff};
         end
         S_M_THETA: begin
            mul_a = {{14{p_ff[17]}}, p_ff};
            mul_b = ppcm_pkg::THETA_K;
         end
         S_M_OMEGA: begin
            mul_a = {{16{r_ff[15]}}, r_ff};
            mul_b = ppcm_pkg::OMEGA_K;
         end
         S_M_TURN: begin
            mul_a = {{14{p_ff[17]}}, p_ff};
            mul_b = ppcm_pkg::TURN_K;
         end
         S_M_E1: begin
            mul_a = {8'b0, gain_angle_ff};
            mul_b = {{12{diff[19]}}, diff};
         end
         S_M_E2: begin
            mul_a = {8'b0, gain_rate_ff};
            mul_b = {{11{omega_ff[20]}}, omega_ff};
         end
         S_M_CMD: begin
            mul_a = {1'b0, s_ff};
            mul_b = {8'b0, spin_gain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // iterative units
   logic               cor_start, cor_done;
   logic signed [17:0] cor_sin, cor_cos;
   logic               div_start, div_done;
   logic [ppcm_pkg::DIVW-1:0] div_dividend, div_quo;
   logic [ppcm_pkg::DVSW-1:0] div_divisor;
   logic               sq_start, sq_done;
   logic [ppcm_pkg::SQW-1:0]   sq_in;
   logic [ppcm_pkg::SQW/2-1:0] sq_root;
   logic [29:0]        u2_mag;
   logic [15:0]        arm_eff;
   logic signed [46:0] f_sel;

   assign cor_start = (state_ff == S_SIN_START) || (state_ff == S_M_E2);
   assign div_start = (state_ff == S_DIV1_START) || (state_ff == S_DIV2_START);
   assign sq_start  = (state_ff == S_SQ_START);

   always_comb begin
      u2_mag  = u2_ff[29] ? 30'(-u2_ff) : 30'(u2_ff);
      arm_eff = (arm_length_ff == 16'd0) ? 16'd1 : arm_length_ff;
      if (state_ff == S_DIV1_START) begin
         div_dividend = {6'b0, hover_force_ff, 16'b0};
         div_divisor  = cs_ff[16:0];
      end else begin
         div_dividend = {u2_mag, 16'b0};
         div_divisor  = {arm_eff, 1'b0};
      end
      f_sel = side_ff ? ff_back : ff_front;
      // drop non-positive forces to a zero root
      sq_in = (f_sel > 47'sd0) ? {f_sel[47-2:0], 16'b0, 1'b0} >> 1 : '0;
   end

   ppcm_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   ((state_ff == S_SIN_START) ? phase_ff : pturn_ff),
      .done    (cor_done),
      .sin_q16 (cor_sin),
      .cos_q16 (cor_cos)
   );

   ppcm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   ppcm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_in),
      .done     (sq_done),
      .root     (sq_root)
   );

   // motor command from the registered product
   logic signed [39:0] m_val;
   always_comb begin
      m_val = $signed({1'b0, prod_ff[54:16]}) - $signed({16'b0, spin_offset_ff});
      if (m_val < 40'sd65536) begin
         cmd = 8'd1;
      end else if (m_val[39:16] > 24'd200) begin
         cmd = 8'd200;
      end else begin
         cmd = m_val[23:16];
      end
   end

   logic signed [28:0] e2;
   assign e2 = prod_ff[44:16];

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff       <= S_IDLE;
         phase_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         gain_angle_ff  <= ppcm_pkg::GAIN_ANGLE_RST;
         gain_rate_ff   <= ppcm_pkg::GAIN_RATE_RST;
         amplitude_ff   <= ppcm_pkg::AMPLITUDE_RST;
         phase_step_ff  <= ppcm_pkg::PHASE_STEP_RST;
         hover_force_ff <= ppcm_pkg::HOVER_FORCE_RST;
         arm_length_ff  <= ppcm_pkg::ARM_LENGTH_RST;
         spin_gain_ff   <= ppcm_pkg::SPIN_GAIN_RST;
         spin_offset_ff <= ppcm_pkg::SPIN_OFFSET_RST;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               ppcm_pkg::REG_GAIN_ANGLE:  gain_angle_ff  <= csr_wr_data[23:0];
               ppcm_pkg::REG_GAIN_RATE:   gain_rate_ff   <= csr_wr_data[23:0];
               ppcm_pkg::REG_AMPLITUDE:   amplitude_ff   <= csr_wr_data[16:0];
               ppcm_pkg::REG_PHASE_STEP:  phase_step_ff  <= csr_wr_data;
               ppcm_pkg::REG_HOVER_FORCE: hover_force_ff <= csr_wr_data[23:0];
               ppcm_pkg::REG_ARM_LENGTH:  arm_length_ff  <= csr_wr_data[15:0];
               ppcm_pkg::REG_SPIN_GAIN:   spin_gain_ff   <= csr_wr_data[23:0];
               ppcm_pkg::REG_SPIN_OFFSET: spin_offset_ff <= csr_wr_data[23:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  p_ff     <= req_chan.pitch_raw;
                  r_ff     <= req_chan.pitch_rate_raw;
                  phase_ff <= phase_ff + phase_step_ff;
                  state_ff <= S_SIN_START;
               end
            end
            S_SIN_START: state_ff <= S_SIN_WAIT;
            S_SIN_WAIT: begin
               if (cor_done) begin
                  sn_ff    <= cor_sin;
                  state_ff <= S_M_DES;
               end
            end
            S_M_DES:   state_ff <= S_M_THETA;
            S_M_THETA: begin
               des_ff   <= prod_ff[33:16];
               state_ff <= S_M_OMEGA;
            end
            S_M_OMEGA: begin
               theta_ff <= prod_ff[42:24];
               state_ff <= S_M_TURN;
            end
            S_M_TURN: begin
               omega_ff <= prod_ff[36:16];
               state_ff <= S_M_E1;
            end
            S_M_E1: begin
               pturn_ff <= prod_ff[47:16];
               state_ff <= S_M_E2;
            end
            S_M_E2: begin
               e1_ff    <= prod_ff[43:16];
               state_ff <= S_U2;
            end
            S_U2: begin
               u2_ff    <= -{{2{e1_ff[27]}}, e1_ff} - {e2[28], e2};
               state_ff <= S_COS_WAIT;
            end
            S_COS_WAIT: begin
               if (cor_done) begin
                  // floor the cosine near and past ninety degrees
                  cs_ff    <= (cor_cos < ppcm_pkg::COS_FLOOR) ? ppcm_pkg::COS_FLOOR : cor_cos;
                  state_ff <= S_DIV1_START;
               end
            end
            S_DIV1_START: state_ff <= S_DIV1_WAIT;
            S_DIV1_WAIT: begin
               if (div_done) begin
                  u4_ff    <= div_quo[30:0];
                  state_ff <= S_DIV2_START;
               end
            end
            S_DIV2_START: state_ff <= S_DIV2_WAIT;
            S_DIV2_WAIT: begin
               if (div_done) begin
                  t_ff     <= u2_ff[29] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
                  state_ff <= S_FORCE;
               end
            end
            S_FORCE: begin
               ff_front <= $signed({17'b0, u4_ff[30:1]}) + t_ff;
               ff_back  <= $signed({17'b0, u4_ff[30:1]}) - t_ff;
               side_ff  <= 1'b0;
               state_ff <= S_SQ_START;
            end
            S_SQ_START: state_ff <= S_SQ_WAIT;
            S_SQ_WAIT: begin
               if (sq_done) begin
                  s_ff     <= sq_root[30:0];
                  state_ff <= S_M_CMD;
               end
            end
            S_M_CMD: state_ff <= S_CMD;
            S_CMD: begin
               if (side_ff) begin
                  mb_ff    <= cmd;
                  state_ff <= S_OUT;
               end else begin
                  mf_ff    <= cmd;
                  side_ff  <= 1'b1;
                  state_ff <= S_SQ_START;
               end
            end
            S_OUT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  out_front_ff <= mf_ff;
                  out_back_ff  <= mb_ff;
                  out_des_ff   <= des_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.motor_front   = out_front_ff;
   assign rsp_chan.motor_back    = out_back_ff;
   assign rsp_chan.desired_pitch = out_des_ff;
endmodule
